### hdl/gtig_pkg.sv
// Package of the grid triangle index generator: shared widths, register indexes
// and the structs that pass configuration, walk state and results between modules.
// No dependencies.
package gtig_pkg;

	localparam int DIM_W     = 11;
	localparam int OFS_W     = 20;
	localparam int IDX_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_ROWS       = 3'd0,
		CFG_GRID_COLS       = 3'd1,
		CFG_WRAP_HORIZONTAL = 3'd2,
		CFG_WRAP_VERTICAL   = 3'd3,
		CFG_BASE_INDEX      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] grid_rows;
		logic [DIM_W-1:0] grid_cols;
		logic             wrap_horizontal;
		logic             wrap_vertical;
		logic [IDX_W-1:0] base_index;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0] row_pos;
		logic [DIM_W-1:0] col_pos;
		logic [OFS_W-1:0] row_offset;
		logic             second_half;
		logic             sequence_done;
	} walk_t;

	typedef struct packed {
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
		logic             is_last;
		logic             finished;
	} tri_t;

endpackage

### hdl/gtig_tri.sv
// Triangle step logic: from the walk state and configuration, forms one triangle
// and the next walk state. Purely combinational. Depends on gtig_pkg.
module gtig_tri #(
	parameter int MAX_DIM = 1024
) (
	input  gtig_pkg::cfg_t  cfg,
	input  gtig_pkg::walk_t walk,
	input  logic            restart,
	output gtig_pkg::tri_t  result,
	output gtig_pkg::walk_t walk_nxt
);

	// Saturation limit, clipped to what an 11-bit register can hold anyway.
	localparam int SAT_INT = (MAX_DIM > (2 ** gtig_pkg::DIM_W) - 1) ?
		(2 ** gtig_pkg::DIM_W) - 1 : MAX_DIM;
	localparam logic [gtig_pkg::DIM_W-1:0] SAT_DIM = gtig_pkg::DIM_W'(SAT_INT);

	gtig_pkg::walk_t              st;
	logic [gtig_pkg::DIM_W-1:0]   rows;
	logic [gtig_pkg::DIM_W-1:0]   cols;
	logic [gtig_pkg::DIM_W:0]     cell_rows;
	logic [gtig_pkg::DIM_W:0]     cell_cols;
	logic [gtig_pkg::DIM_W:0]     row_inc;
	logic [gtig_pkg::DIM_W:0]     col_inc;
	logic [gtig_pkg::OFS_W-1:0]   ofs_down;
	logic [gtig_pkg::OFS_W-1:0]   next_row;
	logic [gtig_pkg::DIM_W-1:0]   next_col;
	logic [gtig_pkg::IDX_W-1:0]   cur_idx;
	logic [gtig_pkg::IDX_W-1:0]   right_idx;
	logic [gtig_pkg::IDX_W-1:0]   below_idx;
	logic [gtig_pkg::IDX_W-1:0]   rb_idx;
	logic                         empty;
	logic                         last;

	always_comb begin
		st = restart ? '0 : walk;

		rows = (cfg.grid_rows > SAT_DIM) ? SAT_DIM : cfg.grid_rows;
		cols = (cfg.grid_cols > SAT_DIM) ? SAT_DIM : cfg.grid_cols;

		cell_rows = (rows == '0) ? '0 :
			({1'b0, rows} - 12'd1 + {{gtig_pkg::DIM_W{1'b0}}, cfg.wrap_vertical});
		cell_cols = (cols == '0) ? '0 :
			({1'b0, cols} - 12'd1 + {{gtig_pkg::DIM_W{1'b0}}, cfg.wrap_horizontal});

		row_inc = {1'b0, st.row_pos} + 12'd1;
		col_inc = {1'b0, st.col_pos} + 12'd1;

		empty = st.sequence_done || ({1'b0, st.row_pos} >= cell_rows) ||
			({1'b0, st.col_pos} >= cell_cols);

		ofs_down = st.row_offset + {{(gtig_pkg::OFS_W-gtig_pkg::DIM_W){1'b0}}, cols};
		next_row = (row_inc >= {1'b0, rows}) ? '0 : ofs_down;
		next_col = (col_inc >= {1'b0, cols}) ? '0 : col_inc[gtig_pkg::DIM_W-1:0];

		cur_idx   = cfg.base_index + 32'(st.row_offset) + 32'(st.col_pos);
		right_idx = cfg.base_index + 32'(st.row_offset) + 32'(next_col);
		below_idx = cfg.base_index + 32'(next_row) + 32'(st.col_pos);
		rb_idx    = cfg.base_index + 32'(next_row) + 32'(next_col);

		last = st.second_half && (row_inc == cell_rows) && (col_inc == cell_cols);

		result   = '0;
		walk_nxt = st;
		if (empty) begin
			result.finished        = 1'b1;
			walk_nxt.sequence_done = 1'b1;
		end else begin
			result.corner_a = st.second_half ? rb_idx : below_idx;
			result.corner_b = st.second_half ? right_idx : rb_idx;
			result.corner_c = cur_idx;
			result.is_last  = last;
			if (!st.second_half) begin
				walk_nxt.second_half = 1'b1;
			end else if (last) begin
				walk_nxt.second_half   = 1'b0;
				walk_nxt.sequence_done = 1'b1;
			end else begin
				walk_nxt.second_half = 1'b0;
				if (col_inc < cell_cols) begin
					walk_nxt.col_pos = col_inc[gtig_pkg::DIM_W-1:0];
				end else begin
					walk_nxt.col_pos    = '0;
					walk_nxt.row_pos    = row_inc[gtig_pkg::DIM_W-1:0];
					walk_nxt.row_offset = ofs_down;
				end
			end
		end
	end

endmodule

### hdl/grid_triangle_index_generator.sv
// Grid triangle index generator, top level: stream ports, configuration registers,
// input and result registers around the step logic. Depends on gtig_pkg, gtig_tri.
// A request beat is registered; its triangle enters the result register once that
// register is empty or being drained. Throughput: one triangle per cycle while
// requests arrive and m_tready is high. Reset (arst_n, asynchronous, active low)
// restores the register defaults and rewinds the walk to the grid's first triangle.
module grid_triangle_index_generator #(
	parameter int MAX_DIM = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream. s_tdata: bit 0 restart, bits 7:1 zero.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// Triangle stream. m_tdata: corner_a [31:0], corner_b [63:32], corner_c [95:64].
	// m_tlast is is_last; m_tuser: bit 0 finished.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,
	output logic        m_tlast,
	output logic [0:0]  m_tuser,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gtig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gtig_pkg::CFG_DAT_W-1:0]    cfg_data
);

	gtig_pkg::cfg_t  cfg_q;
	gtig_pkg::walk_t walk_q;
	gtig_pkg::walk_t walk_nxt;
	gtig_pkg::tri_t  tri_res;
	gtig_pkg::tri_t  res_s2;

	logic valid_s1;
	logic restart_s1;
	logic valid_s2;
	logic advance;

	// Configuration is always taken; writes to unlisted indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows       <= gtig_pkg::DIM_W'(2);
			cfg_q.grid_cols       <= gtig_pkg::DIM_W'(2);
			cfg_q.wrap_horizontal <= 1'b0;
			cfg_q.wrap_vertical   <= 1'b0;
			cfg_q.base_index      <= '0;
		end else if (cfg_valid) begin
			case (gtig_pkg::cfg_idx_t'(cfg_index))
				gtig_pkg::CFG_GRID_ROWS: begin
					cfg_q.grid_rows <= cfg_data[gtig_pkg::DIM_W-1:0];
				end
				gtig_pkg::CFG_GRID_COLS: begin
					cfg_q.grid_cols <= cfg_data[gtig_pkg::DIM_W-1:0];
				end
				gtig_pkg::CFG_WRAP_HORIZONTAL: begin
					cfg_q.wrap_horizontal <= cfg_data[0];
				end
				gtig_pkg::CFG_WRAP_VERTICAL: begin
					cfg_q.wrap_vertical <= cfg_data[0];
				end
				gtig_pkg::CFG_BASE_INDEX: begin
					cfg_q.base_index <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The registered request moves into the result register whenever that
	// register is empty or being drained; the walk state steps at that moment.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	gtig_tri #(
		.MAX_DIM(MAX_DIM)
	) u_tri (
		.cfg     (cfg_q),
		.walk    (walk_q),
		.restart (restart_s1),
		.result  (tri_res),
		.walk_nxt(walk_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			walk_q   <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				walk_q   <= walk_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			restart_s1 <= s_tdata[0];
		end
		if (advance) begin
			res_s2 <= tri_res;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = {res_s2.corner_c, res_s2.corner_b, res_s2.corner_a};
	assign m_tlast    = res_s2.is_last;
	assign m_tuser[0] = res_s2.finished;

	// A finished beat carries zero corners and never marks the last triangle.
	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
		else $error("finished beat with nonzero corners or last flag");

	// A first-half triangle sets the walk state to the second half of its cell.
	a_half_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !tri_res.finished && !walk_nxt.sequence_done && !tri_res.is_last &&
		!(restart_s1 ? 1'b0 : walk_q.second_half) |=> walk_q.second_half)
		else $error("second half of a cell not scheduled");

	// The last triangle of a grid ends the walk.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tri_res.is_last |=> walk_q.sequence_done)
		else $error("walk not ended after the last triangle");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the grid triangle index generator.
// Holds a triangle scoreboard class, tasks for the request and configuration channels
// and a receiver process; depends only on gtig_pkg and the generator's top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// The generator is built with its default dimension limit, and the predictor saturates
	// the grid sizes at the same value.
	localparam int GRID_MAX     = 1024;
	// Cycles without any accepted beat on any channel before the run is declared hung.
	localparam int QUIET_LIMIT  = 2000;
	// Number of random request beats that follow the directed part.
	localparam int RANDOM_BEATS = 1900;
	// Walk cap for one grid, extra beats aside; large grids are only sampled at their start.
	localparam int WALK_CAP     = 60;

	// The scoreboard keeps its own copy of the configuration registers and of the walk
	// position. Every accepted request advances that copy and queues the triangle it must
	// produce; every accepted triangle beat is compared with the oldest queued one.
	class triangle_tracker;
		bit [gtig_pkg::DIM_W-1:0] grid_rows;
		bit [gtig_pkg::DIM_W-1:0] grid_cols;
		bit                       wrap_h;
		bit                       wrap_v;
		bit [gtig_pkg::IDX_W-1:0] base_index;

		bit [15:0]                row_pos;
		bit [15:0]                col_pos;
		bit [gtig_pkg::OFS_W-1:0] row_offset;
		bit                       second_half;
		bit                       walk_done;

		gtig_pkg::tri_t           due_tris[$];
		int                       errors;
		int                       checked;

		function new();
			grid_rows   = 2;
			grid_cols   = 2;
			wrap_h      = 0;
			wrap_v      = 0;
			base_index  = '0;
			rewind();
			errors      = 0;
			checked     = 0;
		endfunction

		function void rewind();
			row_pos     = '0;
			col_pos     = '0;
			row_offset  = '0;
			second_half = 0;
			walk_done   = 0;
		endfunction

		function void write_reg(gtig_pkg::cfg_idx_t idx, bit [gtig_pkg::CFG_DAT_W-1:0] data);
			case (idx)
				gtig_pkg::CFG_GRID_ROWS:       grid_rows  = data[gtig_pkg::DIM_W-1:0];
				gtig_pkg::CFG_GRID_COLS:       grid_cols  = data[gtig_pkg::DIM_W-1:0];
				gtig_pkg::CFG_WRAP_HORIZONTAL: wrap_h     = data[0];
				gtig_pkg::CFG_WRAP_VERTICAL:   wrap_v     = data[0];
				gtig_pkg::CFG_BASE_INDEX:      base_index = data[gtig_pkg::IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_tris.size();
		endfunction

		// Sizes after saturation and the number of cell rows and columns, seam cells included.
		function bit [31:0] eff_dim(bit [gtig_pkg::DIM_W-1:0] v);
			return (v > GRID_MAX) ? GRID_MAX : v;
		endfunction

		function bit [31:0] cell_count(bit [gtig_pkg::DIM_W-1:0] v, bit wrap);
			bit [31:0] d;
			d = eff_dim(v);
			return (d == 0) ? 32'd0 : d - 32'd1 + wrap;
		endfunction

		function void predict_triangle(bit restart);
			bit [31:0]      rows, cols, cell_rows, cell_cols;
			bit [31:0]      next_row, next_col, cur, right, below, diag;
			bit             last;
			gtig_pkg::tri_t t;
			rows = eff_dim(grid_rows);
			cols = eff_dim(grid_cols);
			if (restart)
				rewind();
			cell_rows = cell_count(grid_rows, wrap_v);
			cell_cols = cell_count(grid_cols, wrap_h);
			t = '0;
			// Past the end, on an empty grid, or with the position outside a shrunken grid,
			// the beat only reports that nothing is left.
			if (walk_done || row_pos >= cell_rows || col_pos >= cell_cols) begin
				walk_done  = 1;
				t.finished = 1;
				due_tris.insert(due_tris.size(), t);
				return;
			end
			// Neighbors in the last row or column wrap to the first one.
			next_row = (row_pos + 32'd1 >= rows) ? 32'd0 : ((row_offset + cols) & 32'hF_FFFF);
			next_col = (col_pos + 32'd1 >= cols) ? 32'd0 : col_pos + 32'd1;
			cur   = base_index + row_offset + col_pos;
			right = base_index + row_offset + next_col;
			below = base_index + next_row + col_pos;
			diag  = base_index + next_row + next_col;
			if (!second_half) begin
				t.corner_a = below;
				t.corner_b = diag;
			end else begin
				t.corner_a = diag;
				t.corner_b = right;
			end
			t.corner_c = cur;
			last = second_half && (row_pos + 32'd1 == cell_rows) && (col_pos + 32'd1 == cell_cols);
			t.is_last = last;
			due_tris.insert(due_tris.size(), t);
			if (!second_half) begin
				second_half = 1;
			end else if (last) begin
				walk_done   = 1;
				second_half = 0;
			end else begin
				second_half = 0;
				if (col_pos + 32'd1 < cell_cols) begin
					col_pos = col_pos + 16'd1;
				end else begin
					col_pos    = '0;
					row_pos    = row_pos + 16'd1;
					row_offset = row_offset + cols[gtig_pkg::OFS_W-1:0];
				end
			end
		endfunction

		task report_mismatch(string field, logic [gtig_pkg::IDX_W-1:0] got,
			logic [gtig_pkg::IDX_W-1:0] want);
			$display("[%0t] triangle %0d: %s is %h, expected %h", $time, checked, field, got, want);
			errors++;
		endtask

		task check_triangle(gtig_pkg::tri_t got);
			gtig_pkg::tri_t want;
			if (due_tris.size() == 0) begin
				report_mismatch("unrequested beat, corner_a", got.corner_a, '0);
				return;
			end
			want = due_tris.pop_front();
			if (got.corner_a !== want.corner_a)
				report_mismatch("corner_a", got.corner_a, want.corner_a);
			if (got.corner_b !== want.corner_b)
				report_mismatch("corner_b", got.corner_b, want.corner_b);
			if (got.corner_c !== want.corner_c)
				report_mismatch("corner_c", got.corner_c, want.corner_c);
			if (got.is_last !== want.is_last)
				report_mismatch("is_last", gtig_pkg::IDX_W'(got.is_last),
					gtig_pkg::IDX_W'(want.is_last));
			if (got.finished !== want.finished)
				report_mismatch("finished", gtig_pkg::IDX_W'(got.finished),
					gtig_pkg::IDX_W'(want.finished));
			checked++;
		endtask
	endclass

	// Patterns of the triangle receiver: always ready, coin flips, a fixed comb of regular
	// stalls, and mostly ready with occasional long stalls.
	typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPELLS} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [gtig_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gtig_pkg::CFG_DAT_W-1:0] cfg_data;

	triangle_tracker tracker = new();

	int             beats_sent   = 0;
	int             quiet_cycles = 0;
	int             burst_left   = 0;
	bit             steady_phase = 0;
	rx_mode_t       rx_mode      = RX_OPEN;
	int             rx_left      = 0;
	int             rx_stall     = 0;
	int             rx_tick      = 0;
	gtig_pkg::tri_t seen_tri;

	grid_triangle_index_generator #(
		.MAX_DIM(GRID_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// All three channels are sampled at the rising edge, where the stimulus driven at the
	// previous falling edge is stable. A configuration write and a request never share an
	// edge, because registers are only written while the request channel is idle.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			tracker.write_reg(gtig_pkg::cfg_idx_t'(cfg_index), cfg_data);
		if (s_tvalid && s_tready)
			tracker.predict_triangle(s_tdata[0]);
		if (m_tvalid && m_tready) begin
			seen_tri.corner_a = m_tdata[31:0];
			seen_tri.corner_b = m_tdata[63:32];
			seen_tri.corner_c = m_tdata[95:64];
			seen_tri.is_last  = m_tlast;
			seen_tri.finished = m_tuser[0];
			tracker.check_triangle(seen_tri);
		end
		if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// A run that stops accepting beats anywhere is ended here.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	// The receiver changes its stall pattern after a random run, so that stalls land
	// on every phase of the sender's bursts.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			RX_COMB: m_tready <= (rx_tick % 4) != 3;
			default: begin
				if (rx_stall > 0) begin
					rx_stall--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 19) == 0) begin
					rx_stall = $urandom_range(4, 24);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// Sends one request beat. The sender works in bursts; between bursts it may drop tvalid
	// for a random gap, unless the current phase runs without gaps.
	task send_beat(bit restart);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 4);
				default:    gap = $urandom_range(5, 20);
			endcase
			if (steady_phase)
				gap = 0;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Stops the sender and waits until every queued triangle has been received.
	task wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Each register write happens only once the generator has nothing left in flight.
	task write_reg(gtig_pkg::cfg_idx_t idx, bit [gtig_pkg::CFG_DAT_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Grid sizes just below, at and beyond the dimension limit.
	function bit [gtig_pkg::DIM_W-1:0] pick_wide_dim();
		case ($urandom_range(0, 3))
			0:       return gtig_pkg::DIM_W'(GRID_MAX);
			1:       return 11'h7FF;
			2:       return gtig_pkg::DIM_W'(GRID_MAX - 1);
			default: return gtig_pkg::DIM_W'($urandom_range(GRID_MAX + 1, 2046));
		endcase
	endfunction

	initial begin
		int                 random_start;
		int                 rows, cols, walk, split;
		bit [31:0]          cells;
		gtig_pkg::cfg_idx_t idx;
		bit [31:0]          value;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = gtig_pkg::CFG_GRID_ROWS;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Out of reset the default two by two grid is walked without a restart: two
		// triangles, the second flagged last, then a finished beat and a restart.
		send_beat(1'b0);
		send_beat(1'b0);
		send_beat(1'b0);
		send_beat(1'b1);

		// Both seams on a two by two grid: the seam cells and the corner cell reuse the
		// first row and column, and a base near the top makes the larger index sums wrap.
		write_reg(gtig_pkg::CFG_GRID_ROWS, 32'd2);
		write_reg(gtig_pkg::CFG_GRID_COLS, 32'd2);
		write_reg(gtig_pkg::CFG_WRAP_HORIZONTAL, 32'd1);
		write_reg(gtig_pkg::CFG_WRAP_VERTICAL, 32'd1);
		write_reg(gtig_pkg::CFG_BASE_INDEX, 32'hFFFF_FFFE);
		send_beat(1'b1);
		repeat (8) send_beat(1'b0);

		// A single row without vertical wrap has no cells, and neither has a zero size.
		write_reg(gtig_pkg::CFG_GRID_ROWS, 32'd1);
		write_reg(gtig_pkg::CFG_WRAP_VERTICAL, 32'd0);
		send_beat(1'b1);
		send_beat(1'b0);
		write_reg(gtig_pkg::CFG_GRID_ROWS, 32'd0);
		send_beat(1'b1);

		// Sizes above the limit saturate. Shrinking the columns in the middle of the walk
		// leaves the kept position outside the grid, which ends the sequence.
		write_reg(gtig_pkg::CFG_GRID_ROWS, 32'h7FF);
		write_reg(gtig_pkg::CFG_GRID_COLS, 32'h7FF);
		write_reg(gtig_pkg::CFG_WRAP_HORIZONTAL, 32'd0);
		write_reg(gtig_pkg::CFG_BASE_INDEX, 32'd0);
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b0);
		write_reg(gtig_pkg::CFG_GRID_COLS, 32'd1);
		send_beat(1'b0);

		// Random phases: each one sets up a grid, mostly a small one, and walks it, mostly from a
		// restart, to a few beats past its end. Long grids are walked only in part. Now and
		// then a restart lands in the middle, the sender drains, or a register changes
		// while the walk is under way.
		random_start = beats_sent;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
					rows = $urandom_range(0, 6);
					cols = $urandom_range(0, 6);
				end
				14, 15, 16: begin
					rows = $urandom_range(1, 12);
					cols = $urandom_range(1, 4);
				end
				default: begin
					rows = pick_wide_dim();
					cols = $urandom_range(0, 1) ? pick_wide_dim() : $urandom_range(0, 3);
				end
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(gtig_pkg::CFG_GRID_ROWS, rows);
			if ($urandom_range(0, 3) != 0)
				write_reg(gtig_pkg::CFG_GRID_COLS, cols);
			if ($urandom_range(0, 1) != 0)
				write_reg(gtig_pkg::CFG_WRAP_HORIZONTAL, $urandom_range(0, 1));
			if ($urandom_range(0, 1) != 0)
				write_reg(gtig_pkg::CFG_WRAP_VERTICAL, $urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0:       write_reg(gtig_pkg::CFG_BASE_INDEX, 32'd0);
					1:       write_reg(gtig_pkg::CFG_BASE_INDEX,
						32'hFFFF_FFFF - $urandom_range(0, 64));
					default: write_reg(gtig_pkg::CFG_BASE_INDEX, $urandom);
				endcase
			end

			// The length of the walk follows from the settings now in force.
			cells = tracker.cell_count(tracker.grid_rows, tracker.wrap_v)
				* tracker.cell_count(tracker.grid_cols, tracker.wrap_h);
			walk  = (2 * cells > WALK_CAP) ? WALK_CAP : 2 * cells;
			walk  = walk + $urandom_range(0, 3);
			split = ($urandom_range(0, 5) == 0) ? $urandom_range(0, walk) : -1;
			steady_phase = ($urandom_range(0, 3) == 0);

			send_beat($urandom_range(0, 7) != 0);
			for (int k = 0; k < walk; k++) begin
				if (k == split) begin
					idx = gtig_pkg::cfg_idx_t'($urandom_range(0, 4));
					case (idx)
						gtig_pkg::CFG_GRID_ROWS, gtig_pkg::CFG_GRID_COLS:
							value = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 2047);
						gtig_pkg::CFG_WRAP_HORIZONTAL, gtig_pkg::CFG_WRAP_VERTICAL:
							value = $urandom_range(0, 1);
						default:
							value = $urandom;
					endcase
					write_reg(idx, value);
				end else if ($urandom_range(0, 39) == 0) begin
					wait_idle();
				end
				send_beat($urandom_range(0, 49) == 0);
			end
		end

		// Let the last triangles drain, then give any stray beat time to show up.
		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
